[rtl/roi_pixel_temporal_mean_stdev_macros.svh]
// Assertion helpers for the ROI statistics block.
`ifndef ROI_PIXEL_TEMPORAL_MEAN_STDEV_MACROS_SVH
`define ROI_PIXEL_TEMPORAL_MEAN_STDEV_MACROS_SVH

`ifndef SYNTH
`define RPTMS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rptms assertion failed");
`define RPTMS_NEVER(lbl, clk, rst_n, expr) \
    `RPTMS_ASSERT(lbl, clk, rst_n, !(expr))
`else
`define RPTMS_ASSERT(lbl, clk, rst_n, prop)
`define RPTMS_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

[rtl/rptms_pkg.sv]
`timescale 1ns / 1ps
package rptms_pkg;

    localparam int CNT_W   = 16;
    localparam int SUM_W   = 31;
    localparam int SQ_W    = 46;
    localparam int COORD_W = 10;
    localparam int DEPTH_W = 16;
    localparam int MAG_W   = 15;
    localparam int SQR_W   = 30;
    localparam int OUT_W   = 23;
    localparam int FRAC_W  = 8;
    localparam int VFRAC_W = 16;
    localparam int LEFT_W  = 10;
    localparam int SIZE_W  = 7;
    localparam int CFGD_W  = 10;
    localparam int CFGI_W  = 2;

    // mean: (sum << 8) / count, var: (d << 16) / count^2
    localparam int MDIV_DW = SUM_W + FRAC_W;
    localparam int MDIV_QW = OUT_W;
    localparam int NQ_W    = 62;
    localparam int N2_W    = 2 * CNT_W;
    localparam int VDIV_DW = NQ_W + VFRAC_W;
    localparam int VDIV_QW = 47;
    localparam int ROOT_W  = (VDIV_QW + 1) / 2;
    localparam int QLO_W   = 23;
    localparam int QHI_W   = SQ_W - QLO_W;
    localparam int PP_W    = CNT_W + QLO_W;

    typedef enum logic [CFGI_W-1:0] {
        CFG_LEFT    = 2'd0,
        CFG_TOP     = 2'd1,
        CFG_COLUMNS = 2'd2,
        CFG_ROWS    = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        REQ_ACC  = 1'b0,
        REQ_READ = 1'b1
    } t_req;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sq;
    } t_entry;

    typedef struct packed {
        logic   valid;
        logic   in_roi;
        t_entry ent;
    } t_stat_req;

endpackage

[rtl/rptms_div.sv]
`timescale 1ns / 1ps
module rptms_div import rptms_pkg::*; #(
    parameter int DW = 39,
    parameter int VW = 16,
    parameter int QW = 23
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic [QW-1:0] o_quot
);

    // one quotient bit per stage; the upper dividend bits are known to be below the divisor
    logic [VW-1:0] r_rem  [QW];
    logic [VW-1:0] r_dv   [QW];
    logic [QW-1:0] r_bits [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [VW-1:0] rem_in;
        logic [VW-1:0] dv_in;
        logic [QW-1:0] bits_in;
        logic [VW:0]   n_trial;
        logic [VW:0]   n_diff;

        if (k == 0) begin : g_first
            assign rem_in  = VW'(i_dividend >> QW);
            assign dv_in   = i_divisor;
            assign bits_in = i_dividend[QW-1:0];
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign dv_in   = r_dv[k-1];
            assign bits_in = r_bits[k-1];
        end

        assign n_trial = {rem_in, bits_in[QW-1]};
        assign n_diff  = n_trial - {1'b0, dv_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[k] <= dv_in;
                if (!n_diff[VW]) begin
                    r_rem[k]  <= n_diff[VW-1:0];
                    r_bits[k] <= {bits_in[QW-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= n_trial[VW-1:0];
                    r_bits[k] <= {bits_in[QW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quot = r_bits[QW-1];

endmodule

[rtl/rptms_sqrt.sv]
`timescale 1ns / 1ps
module rptms_sqrt import rptms_pkg::*; #(
    parameter int IW = 47
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [IW-1:0]         i_value,
    output logic [(IW+1)/2-1:0]   o_root
);

    localparam int RW = (IW + 1) / 2;
    localparam int PW = 2 * RW;

    // one root bit per stage, two radicand bits consumed each
    logic [RW+1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [PW-1:0] r_bits [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RW+1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [PW-1:0] bits_in;
        logic [RW+3:0] n_t;
        logic [RW+3:0] n_diff;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign bits_in = PW'(i_value);
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign bits_in = r_bits[k-1];
        end

        assign n_t    = {rem_in, bits_in[PW-1:PW-2]};
        assign n_diff = n_t - {2'b00, root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_bits[k] <= {bits_in[PW-3:0], 2'b00};
                if (!n_diff[RW+3]) begin
                    r_rem[k]  <= n_diff[RW+1:0];
                    r_root[k] <= {root_in[RW-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= n_t[RW+1:0];
                    r_root[k] <= {root_in[RW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule

[rtl/rptms_stats.sv]
`timescale 1ns / 1ps
module rptms_stats import rptms_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_stat_req        i_req,
    output logic             o_valid,
    output logic             o_inside,
    output logic [CNT_W-1:0] o_count,
    output logic [OUT_W-1:0] o_mean,
    output logic [OUT_W-1:0] o_stdev
);

    localparam int L_VAR  = VDIV_QW + ROOT_W;
    localparam int L_MEAN = L_VAR - MDIV_QW;

    // stage A: partial products
    logic             r_a_valid, r_a_inside;
    logic [CNT_W-1:0] r_a_n;
    logic [SUM_W-1:0] r_a_s;
    logic [PP_W-1:0]  r_a_pl, r_a_ph;
    logic [NQ_W-1:0]  r_a_ss;
    logic [N2_W-1:0]  r_a_n2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_inside <= i_req.in_roi;
            r_a_n      <= i_req.ent.cnt;
            r_a_s      <= i_req.ent.sum;
            r_a_pl     <= PP_W'(i_req.ent.cnt * i_req.ent.sq[QLO_W-1:0]);
            r_a_ph     <= PP_W'(i_req.ent.cnt * i_req.ent.sq[SQ_W-1:QLO_W]);
            r_a_ss     <= NQ_W'(i_req.ent.sum * i_req.ent.sum);
            r_a_n2     <= N2_W'(i_req.ent.cnt * i_req.ent.cnt);
        end
    end

    // stage B: n*q - s*s, clamped at zero
    logic             r_b_valid, r_b_inside;
    logic [CNT_W-1:0] r_b_n;
    logic [SUM_W-1:0] r_b_s;
    logic [NQ_W-1:0]  r_b_d;
    logic [N2_W-1:0]  r_b_n2;
    logic [NQ_W-1:0]  n_nq;

    assign n_nq = NQ_W'(r_a_pl) + (NQ_W'(r_a_ph) << QLO_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_inside <= r_a_inside;
            r_b_n      <= r_a_n;
            r_b_s      <= r_a_s;
            r_b_n2     <= r_a_n2;
            r_b_d      <= (n_nq >= r_a_ss) ? (n_nq - r_a_ss) : '0;
        end
    end

    logic [VDIV_QW-1:0] var_q;
    logic [MDIV_QW-1:0] mean_q;
    logic [ROOT_W-1:0]  root;

    rptms_div #(.DW(VDIV_DW), .VW(N2_W), .QW(VDIV_QW)) u_var_div (
        .i_clk      (i_clk),
        .i_en       (i_en),
        .i_dividend ({r_b_d, {VFRAC_W{1'b0}}}),
        .i_divisor  (r_b_n2),
        .o_quot     (var_q)
    );

    rptms_sqrt #(.IW(VDIV_QW)) u_sqrt (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_value (var_q),
        .o_root  (root)
    );

    rptms_div #(.DW(MDIV_DW), .VW(CNT_W), .QW(MDIV_QW)) u_mean_div (
        .i_clk      (i_clk),
        .i_en       (i_en),
        .i_dividend ({r_b_s, {FRAC_W{1'b0}}}),
        .i_divisor  (r_b_n),
        .o_quot     (mean_q)
    );

    // side data follows the divide and root
    logic               r_dl_valid  [L_VAR];
    logic               r_dl_inside [L_VAR];
    logic [CNT_W-1:0]   r_dl_n      [L_VAR];
    logic [MDIV_QW-1:0] r_dl_mean   [L_MEAN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < L_VAR; k++) r_dl_valid[k] <= 1'b0;
        end else if (i_en) begin
            r_dl_valid[0] <= r_b_valid;
            for (int k = 1; k < L_VAR; k++) r_dl_valid[k] <= r_dl_valid[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dl_inside[0] <= r_b_inside;
            r_dl_n[0]      <= r_b_n;
            for (int k = 1; k < L_VAR; k++) begin
                r_dl_inside[k] <= r_dl_inside[k-1];
                r_dl_n[k]      <= r_dl_n[k-1];
            end
            r_dl_mean[0] <= mean_q;
            for (int k = 1; k < L_MEAN; k++) r_dl_mean[k] <= r_dl_mean[k-1];
        end
    end

    logic             r_o_valid, r_o_inside;
    logic [CNT_W-1:0] r_o_count;
    logic [OUT_W-1:0] r_o_mean, r_o_stdev;
    logic             n_nz;

    assign n_nz = (r_dl_n[L_VAR-1] != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_en) begin
            r_o_valid <= r_dl_valid[L_VAR-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_inside <= r_dl_inside[L_VAR-1];
            r_o_count  <= r_dl_n[L_VAR-1];
            r_o_mean   <= n_nz ? r_dl_mean[L_MEAN-1] : '0;
            r_o_stdev  <= n_nz ? root[OUT_W-1:0] : '0;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_inside = r_o_inside;
    assign o_count  = r_o_count;
    assign o_mean   = r_o_mean;
    assign o_stdev  = r_o_stdev;

endmodule

[rtl/roi_pixel_temporal_mean_stdev.sv]
`timescale 1ns / 1ps
// Per-pixel temporal mean and standard deviation over a region of interest.
// Input channel (i_valid / o_stall): one transaction per cycle unless stalled. Accumulate
// transactions add a valid depth sample to the pixel's entry; read transactions
// return the pixel's count, mean and population deviation (8 fraction bits).
// Output channel (o_valid / i_stall): one transaction per read, in order.
// Throughput is one transaction per cycle while neither side stalls. Statistics
// live in one read-modify-write memory of ROI_MAX_COLS * ROI_MAX_ROWS entries; a
// write followed by a read of the same entry in the next cycle is bypassed.
// A read passes from the accepting edge to o_valid through the memory read at
// acceptance, a multiply stage, a subtract stage, a 47-stage divider for the
// variance, a 24-stage root and the output register. The mean divider runs alongside.
// After reset the block clears all ROI_MAX_COLS * ROI_MAX_ROWS entries (4096 by
// default) of the memory, one entry per cycle, holding o_stall high;
// configuration writes are taken during that time.
// When the output is stalled with a result pending, the whole pipeline holds
// and o_stall rises until the result is taken.
`include "roi_pixel_temporal_mean_stdev_macros.svh"
module roi_pixel_temporal_mean_stdev import rptms_pkg::*; #(
    parameter int ROI_MAX_COLS      = 64,
    parameter int ROI_MAX_ROWS      = 64,
    parameter int IMAGE_COORD_LIMIT = 1024,
    parameter int COUNT_LIMIT       = 65535
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFGI_W-1:0]         i_cfg_index,
    input  logic [CFGD_W-1:0]         i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_req_type,
    input  logic [COORD_W-1:0]        i_pixel_col,
    input  logic [COORD_W-1:0]        i_pixel_row,
    input  logic signed [DEPTH_W-1:0] i_depth_value,
    input  logic                      i_depth_is_nan,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_inside_region,
    output logic [CNT_W-1:0]          o_valid_count,
    output logic [OUT_W-1:0]          o_mean_depth,
    output logic [OUT_W-1:0]          o_stdev_depth
);

    localparam int DEPTH = ROI_MAX_COLS * ROI_MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LIM_W = 14;
    localparam int EFF_W = 9;

    // configuration
    logic [LEFT_W-1:0] r_roi_left, r_roi_top;
    logic [SIZE_W-1:0] r_roi_columns, r_roi_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roi_left    <= '0;
            r_roi_top     <= '0;
            r_roi_columns <= SIZE_W'(64);
            r_roi_rows    <= SIZE_W'(64);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LEFT:    r_roi_left    <= i_cfg_data[LEFT_W-1:0];
                CFG_TOP:     r_roi_top     <= i_cfg_data[LEFT_W-1:0];
                CFG_COLUMNS: r_roi_columns <= i_cfg_data[SIZE_W-1:0];
                CFG_ROWS:    r_roi_rows    <= i_cfg_data[SIZE_W-1:0];
            endcase
        end
    end

    // pipeline enable and handshakes
    logic en, accept, stat_valid;
    logic r_clearing;

    assign en      = !(stat_valid && i_stall);
    assign o_stall = r_clearing || !en;
    assign accept  = i_valid && !o_stall;

    // locate the pixel in the region
    logic [EFF_W-1:0]   cols_eff, rows_eff;
    logic [COORD_W-1:0] dc, dr;
    logic               in_img, n_inside, n_ok;
    logic [AW-1:0]      n_idx;
    logic [SQR_W-1:0]   n_sq;

    assign cols_eff = ({2'b00, r_roi_columns} > EFF_W'(ROI_MAX_COLS)) ?
                      EFF_W'(ROI_MAX_COLS) : {2'b00, r_roi_columns};
    assign rows_eff = ({2'b00, r_roi_rows} > EFF_W'(ROI_MAX_ROWS)) ?
                      EFF_W'(ROI_MAX_ROWS) : {2'b00, r_roi_rows};
    assign in_img   = (LIM_W'(i_pixel_col) < LIM_W'(IMAGE_COORD_LIMIT)) &&
                      (LIM_W'(i_pixel_row) < LIM_W'(IMAGE_COORD_LIMIT));
    assign dc       = i_pixel_col - r_roi_left;
    assign dr       = i_pixel_row - r_roi_top;
    assign n_inside = in_img && (i_pixel_col >= r_roi_left) && (i_pixel_row >= r_roi_top) &&
                      (dc < COORD_W'(cols_eff)) && (dr < COORD_W'(rows_eff));
    assign n_idx    = AW'(32'(dr) * 32'(ROI_MAX_COLS) + 32'(dc));
    // positive and not NaN
    assign n_ok     = !i_depth_is_nan && !i_depth_value[DEPTH_W-1] && (i_depth_value != '0);
    assign n_sq     = SQR_W'(i_depth_value[MAG_W-1:0] * i_depth_value[MAG_W-1:0]);

    // memory stage
    t_entry r_mem [DEPTH];
    t_entry r_rd_data;
    logic          mem_we, acc_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata, cur, n_upd;
    logic [AW-1:0] r_clr_addr;

    logic              r1_valid, r1_inside, r1_ok;
    t_req              r1_req;
    logic [AW-1:0]     r1_idx;
    logic [MAG_W-1:0]  r1_depth;
    logic [SQR_W-1:0]  r1_sq;

    logic          r_byp_valid;
    logic [AW-1:0] r_byp_idx;
    t_entry        r_byp_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (en) r_rd_data <= r_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1)) r_clearing <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r_byp_valid <= 1'b0;
        end else if (en) begin
            r1_valid    <= accept;
            r_byp_valid <= acc_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_req     <= t_req'(i_req_type);
            r1_inside  <= n_inside;
            r1_ok      <= n_ok;
            r1_idx     <= n_idx;
            r1_depth   <= i_depth_value[MAG_W-1:0];
            r1_sq      <= n_sq;
            r_byp_idx  <= r1_idx;
            r_byp_data <= n_upd;
        end
    end

    assign cur = (r_byp_valid && (r_byp_idx == r1_idx)) ? r_byp_data : r_rd_data;

    always_comb begin
        n_upd     = cur;
        n_upd.cnt = cur.cnt + 1'b1;
        n_upd.sum = cur.sum + SUM_W'(r1_depth);
        n_upd.sq  = cur.sq + SQ_W'(r1_sq);
    end

    assign acc_we    = en && r1_valid && (r1_req == REQ_ACC) && r1_inside && r1_ok &&
                       (cur.cnt < CNT_W'(COUNT_LIMIT));
    assign mem_we    = r_clearing || acc_we;
    assign mem_waddr = r_clearing ? r_clr_addr : r1_idx;
    assign mem_wdata = r_clearing ? t_entry'('0) : n_upd;

    // statistics pipeline
    t_stat_req stat_req;

    always_comb begin
        stat_req.valid  = r1_valid && (r1_req == REQ_READ);
        stat_req.in_roi = r1_inside;
        stat_req.ent    = r1_inside ? cur : t_entry'('0);
    end

    rptms_stats u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_req    (stat_req),
        .o_valid  (stat_valid),
        .o_inside (o_inside_region),
        .o_count  (o_valid_count),
        .o_mean   (o_mean_depth),
        .o_stdev  (o_stdev_depth)
    );

    assign o_valid = stat_valid;

    `RPTMS_NEVER(a_no_accept_while_clearing, i_clk, i_rst_n, r_clearing && accept)
    `RPTMS_NEVER(a_no_update_while_clearing, i_clk, i_rst_n, r_clearing && acc_we)
    `RPTMS_ASSERT(a_hold_on_stall, i_clk, i_rst_n, (r1_valid && !en) |=> r1_valid)
    `RPTMS_NEVER(a_no_update_on_stall, i_clk, i_rst_n, acc_we && !en)

endmodule

[tb/roi_pixel_temporal_mean_stdev_checker.sv]
`timescale 1ns / 1ps
module roi_pixel_temporal_mean_stdev_checker import rptms_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFGI_W-1:0]         i_cfg_index,
    input  logic [CFGD_W-1:0]         i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic                      i_req_type,
    input  logic [COORD_W-1:0]        i_pixel_col,
    input  logic [COORD_W-1:0]        i_pixel_row,
    input  logic signed [DEPTH_W-1:0] i_depth_value,
    input  logic                      i_depth_is_nan,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic                      i_inside_region,
    input  logic [CNT_W-1:0]          i_valid_count,
    input  logic [OUT_W-1:0]          i_mean_depth,
    input  logic [OUT_W-1:0]          i_stdev_depth,
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_reads_checked
);
    localparam int MAX_COLS    = 64;
    localparam int MAX_ROWS    = 64;
    localparam int COORD_LIMIT = 1024;
    localparam int FULL_COUNT  = 65535;

    typedef struct {
        logic             in_roi;
        logic [CNT_W-1:0] count;
        logic [OUT_W-1:0] mean;
        logic [OUT_W-1:0] stdev;
    } t_pixel_stats;

    logic [LEFT_W-1:0] roi_left, roi_top;
    logic [SIZE_W-1:0] roi_cols, roi_rows;
    logic [CNT_W-1:0]  count_mem [MAX_COLS*MAX_ROWS];
    logic [SUM_W-1:0]  sum_mem   [MAX_COLS*MAX_ROWS];
    logic [SQ_W-1:0]   sq_mem    [MAX_COLS*MAX_ROWS];
    t_pixel_stats      stats_due [$];

    assign o_pending = stats_due.size();

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // returns store index, or -1 when the pixel is outside the region
    function automatic int roi_index(int col, int row);
        int cols, rows;
        cols = (roi_cols > MAX_COLS) ? MAX_COLS : roi_cols;
        rows = (roi_rows > MAX_ROWS) ? MAX_ROWS : roi_rows;
        if (col >= COORD_LIMIT || row >= COORD_LIMIT) return -1;
        if (col < roi_left || row < roi_top) return -1;
        if (col - roi_left >= cols || row - roi_top >= rows) return -1;
        return (row - roi_top) * MAX_COLS + (col - roi_left);
    endfunction

    task automatic accept_transaction();
        int idx;
        t_pixel_stats st;
        longint unsigned n, s, q, d, n2, var_fx;
        idx = roi_index(i_pixel_col, i_pixel_row);
        if (i_req_type == REQ_ACC) begin
            if (idx >= 0 && !i_depth_is_nan && i_depth_value > 0 &&
                count_mem[idx] < FULL_COUNT) begin
                count_mem[idx] <= count_mem[idx] + 1'b1;
                sum_mem[idx]   <= sum_mem[idx] + SUM_W'(i_depth_value);
                sq_mem[idx]    <= sq_mem[idx] + SQ_W'(i_depth_value * i_depth_value);
            end
        end else begin
            st = '{in_roi: idx >= 0, count: '0, mean: '0, stdev: '0};
            if (idx >= 0 && count_mem[idx] != 0) begin
                n = count_mem[idx];
                s = sum_mem[idx];
                q = sq_mem[idx];
                d = (n * q >= s * s) ? n * q - s * s : 0;
                n2 = n * n;
                var_fx = (d / n2) * 65536 + ((d % n2) * 65536) / n2;
                st.count = n[CNT_W-1:0];
                st.mean  = OUT_W'((s * 256) / n);
                st.stdev = OUT_W'(int_sqrt(var_fx));
            end
            stats_due = {stats_due, st};
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel_stats exp_st;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            roi_left <= '0;
            roi_top  <= '0;
            roi_cols <= SIZE_W'(64);
            roi_rows <= SIZE_W'(64);
            for (int k = 0; k < MAX_COLS * MAX_ROWS; k++) begin
                count_mem[k] <= '0;
                sum_mem[k]   <= '0;
                sq_mem[k]    <= '0;
            end
            o_errors        <= 0;
            o_reads_checked <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_LEFT:    roi_left <= i_cfg_data[LEFT_W-1:0];
                    CFG_TOP:     roi_top  <= i_cfg_data[LEFT_W-1:0];
                    CFG_COLUMNS: roi_cols <= i_cfg_data[SIZE_W-1:0];
                    CFG_ROWS:    roi_rows <= i_cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) accept_transaction();
            if (i_out_valid && !i_out_stall) begin
                if (stats_due.size() == 0) begin
                    $error("unexpected result transaction");
                    errs++;
                end else begin
                    exp_st = stats_due.pop_front();
                    o_reads_checked <= o_reads_checked + 1;
                    if (i_inside_region !== exp_st.in_roi) begin
                        $error("inside_region: expected %0d, got %0d",
                               exp_st.in_roi, i_inside_region);
                        errs++;
                    end
                    if (i_valid_count !== exp_st.count) begin
                        $error("valid_count: expected %0d, got %0d",
                               exp_st.count, i_valid_count);
                        errs++;
                    end
                    if (i_mean_depth !== exp_st.mean) begin
                        $error("mean_depth: expected %0d, got %0d",
                               exp_st.mean, i_mean_depth);
                        errs++;
                    end
                    if (i_stdev_depth !== exp_st.stdev) begin
                        $error("stdev_depth: expected %0d, got %0d",
                               exp_st.stdev, i_stdev_depth);
                        errs++;
                    end
                end
            end
            o_errors <= o_errors + errs;
        end
    end
endmodule

[tb/roi_pixel_temporal_mean_stdev_test.sv]
`timescale 1ns / 1ps
module roi_pixel_temporal_mean_stdev_test;
    import rptms_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic                      i_clk, i_rst_n;
    logic                      i_cfg_we;
    logic [CFGI_W-1:0]         i_cfg_index;
    logic [CFGD_W-1:0]         i_cfg_data;
    logic                      i_valid, o_stall;
    logic                      i_req_type;
    logic [COORD_W-1:0]        i_pixel_col, i_pixel_row;
    logic signed [DEPTH_W-1:0] i_depth_value;
    logic                      i_depth_is_nan;
    logic                      o_valid, i_stall;
    logic                      o_inside_region;
    logic [CNT_W-1:0]          o_valid_count;
    logic [OUT_W-1:0]          o_mean_depth, o_stdev_depth;

    int errors, pending, reads_checked, sent_items, idle_cycles;
    bit no_idle, long_hold;
    int cur_left, cur_top, cur_cols, cur_rows;

    roi_pixel_temporal_mean_stdev DUT (.*);

    roi_pixel_temporal_mean_stdev_checker stats_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_req_type(i_req_type), .i_pixel_col(i_pixel_col),
        .i_pixel_row(i_pixel_row), .i_depth_value(i_depth_value),
        .i_depth_is_nan(i_depth_is_nan),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_inside_region(o_inside_region), .i_valid_count(o_valid_count),
        .i_mean_depth(o_mean_depth), .i_stdev_depth(o_stdev_depth),
        .o_errors(errors), .o_pending(pending), .o_reads_checked(reads_checked)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog: cycles with no transaction on either channel and no configuration write
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("roi_pixel_temporal_mean_stdev_test: done, errors");
            $finish;
        end
    end

    // result side
    initial begin
        int n;
        bit took;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            n = long_hold ? 400 : (no_idle ? 0 : $urandom_range(0, 4));
            long_hold = 0;
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            forever begin
                @(negedge i_clk);
                took = o_valid;
                @(posedge i_clk);
                if (took) break;
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, int data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFGD_W'(data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_roi(int left, int top, int cols, int rows);
        i_valid <= 1'b0;
        wait (pending == 0);
        repeat (90) @(posedge i_clk);
        write_reg(CFG_LEFT, left);
        write_reg(CFG_TOP, top);
        write_reg(CFG_COLUMNS, cols);
        write_reg(CFG_ROWS, rows);
        cur_left = left;
        cur_top  = top;
        cur_cols = cols > 64 ? 64 : cols;
        cur_rows = rows > 64 ? 64 : rows;
    endtask

    // called right after a rising edge; returns right after the accepting edge
    task automatic send(t_req req, int col, int row, int depth, bit nan);
        int gap;
        bit stalled;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_req_type     <= req;
        i_pixel_col    <= COORD_W'(col);
        i_pixel_row    <= COORD_W'(row);
        i_depth_value  <= DEPTH_W'(depth);
        i_depth_is_nan <= nan;
        forever begin
            @(negedge i_clk);
            stalled = o_stall;
            @(posedge i_clk);
            if (!stalled) break;
        end
        sent_items++;
    endtask

    task automatic pick_pixel(output int col, output int row);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            col = $urandom_range(0, 1023);
            row = $urandom_range(0, 1023);
        end else if (r < 20) begin
            // around the region's far edges
            col = cur_left + cur_cols - 1 + $urandom_range(0, 1);
            row = cur_top + cur_rows - 1 + $urandom_range(0, 1);
        end else begin
            col = cur_left + $urandom_range(0, cur_cols > 4 ? 3 : cur_cols - 1);
            row = cur_top + $urandom_range(0, cur_rows > 4 ? 3 : cur_rows - 1);
        end
        if (col > 1023) col = 1023;
        if (row > 1023) row = 1023;
    endtask

    task automatic random_items(int count);
        int col, row, depth, r;
        bit nan;
        for (int k = 0; k < count; k++) begin
            if (k % 150 == 0) no_idle = ~no_idle;
            pick_pixel(col, row);
            r = $urandom_range(0, 99);
            if (r < 60)      depth = $urandom_range(1, 32767);
            else if (r < 78) depth = $urandom_range(0, 65535);
            else if (r < 86) depth = 0;
            else if (r < 93) depth = 32767;
            else             depth = 1;
            nan = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 99) < 30)
                send(REQ_READ, col, row, $urandom_range(0, 65535), $urandom_range(0, 1));
            else
                send(REQ_ACC, col, row, depth, nan);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_LEFT;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_req_type = REQ_ACC;
        i_pixel_col = '0;
        i_pixel_row = '0;
        i_depth_value = '0;
        i_depth_is_nan = 1'b0;
        sent_items = 0;
        idle_cycles = 0;
        no_idle = 0;
        long_hold = 0;
        cur_left = 0; cur_top = 0; cur_cols = 64; cur_rows = 64;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default region, directed cases
        send(REQ_ACC, 0, 0, 32767, 0);
        send(REQ_ACC, 0, 0, 1, 0);
        send(REQ_ACC, 0, 0, 500, 1);
        send(REQ_ACC, 0, 0, 0, 0);
        send(REQ_ACC, 0, 0, -32768, 0);
        send(REQ_ACC, 0, 0, -1, 0);
        send(REQ_ACC, 63, 63, 100, 0);
        send(REQ_ACC, 64, 0, 5, 0);
        send(REQ_ACC, 1023, 1023, 5, 0);
        send(REQ_READ, 0, 0, 0, 0);
        send(REQ_READ, 63, 63, 0, 0);
        send(REQ_READ, 64, 0, 0, 0);
        send(REQ_READ, 0, 64, 0, 0);
        send(REQ_READ, 1023, 1023, 0, 0);
        send(REQ_READ, 5, 5, 0, 0);
        // back-to-back write then read of one pixel
        no_idle = 1;
        send(REQ_ACC, 2, 2, 7, 0);
        send(REQ_READ, 2, 2, 0, 0);
        no_idle = 0;

        random_items(300);

        // receiver holds off while reads keep coming
        long_hold = 1;
        no_idle = 1;
        for (int k = 0; k < 150; k++) send(REQ_READ, k % 8, 0, 0, 0);
        no_idle = 0;
        i_valid <= 1'b0;
        wait (pending == 0);   // sender pause until drained
        random_items(100);

        set_roi(1000, 1000, 64, 64);
        random_items(250);
        set_roi(37, 511, 1, 1);
        random_items(150);
        set_roi(5, 5, 0, 64);
        random_items(80);
        set_roi(300, 700, 127, 100);
        random_items(250);
        set_roi(0, 0, 64, 64);
        random_items(100);

        send(REQ_READ, 9, 9, 0, 0);
        random_items(50);

        i_valid <= 1'b0;
        wait (pending == 0);
        repeat (100) @(posedge i_clk);
        $display("Sent %0d transactions over six region settings, checked %0d reads,",
                 sent_items, reads_checked);
        $display("including empty, oversized and single-pixel regions with stalls on both sides.");
        if (errors == 0)
            $display("roi_pixel_temporal_mean_stdev_test: done, clean");
        else
            $display("roi_pixel_temporal_mean_stdev_test: done, errors");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/rptms_pkg.sv
rtl/rptms_div.sv
rtl/rptms_sqrt.sv
rtl/rptms_stats.sv
rtl/roi_pixel_temporal_mean_stdev.sv
tb/roi_pixel_temporal_mean_stdev_checker.sv
tb/roi_pixel_temporal_mean_stdev_test.sv
